@@ hw/rtl/lbc_pkg.sv @@
// Shared types and constants for the 3x3 line-buffer convolution block
`default_nettype none
package lbc_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int SUM_W      = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_K0     = 3'd0,
		REG_K1     = 3'd1,
		REG_K2     = 3'd2,
		REG_DIV    = 3'd3,
		REG_OFFSET = 3'd4,
		REG_WIDTH  = 3'd5,
		REG_HEIGHT = 3'd6,
		REG_NONE   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		FS_IDLE = 2'd0,
		FS_READ = 2'd1,
		FS_SUM  = 2'd2
	} fstate_t;

	// one window position handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [9:0]       row;
		logic [9:0]       col;
		logic             last;
	} win_item_t;
endpackage
`default_nettype wire

@@ hw/rtl/line_buffer_conv3x3_unit.sv @@
// Top level of the 3x3 line-buffer convolution block
// Usage:
//   Pixels enter in raster order on pixel_in with valid/ready; one beat per pixel.
//   Results leave on out_value/out_row/out_col/frame_last with out_valid/out_ready,
//   one beat per input pixel with row and column both at least 2.
//   Registers are written through cfg_we/cfg_idx/cfg_data while the block is idle.
//   The front end takes a pixel when idle, then steps through a read state and a sum
//   state (line-store read, then window update and sum) before it is ready again.
//   The back end divides with a 20-step restoring divider and takes a new sum only
//   once the previous result has left; the divider sets sustained throughput.
//   A four-entry queue lets the front keep filling line stores while the divider
//   works.
//   Reset clears counters, queue and registers (divisor 1, size 1024x1024); line
//   stores are not cleared. When out_ready is low the result holds, the divider
//   stops and the queue fills, after which in_ready drops.
`default_nettype none
module line_buffer_conv3x3_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [7:0]                         pixel_in,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [7:0]                         out_value,
	output logic [9:0]                         out_row,
	output logic [9:0]                         out_col,
	output logic                               frame_last,
	input  wire                                cfg_we,
	input  wire  [lbc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire  [lbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	logic [23:0] k0_q, k1_q, k2_q;
	logic [7:0]  div_q, off_q;
	logic [10:0] wid_q, hgt_q;
	logic        push, full, pop, nempty;
	lbc_pkg::win_item_t fitem, qitem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k0_q  <= '0;
			k1_q  <= '0;
			k2_q  <= '0;
			div_q <= 8'd1;
			off_q <= '0;
			wid_q <= 11'd1024;
			hgt_q <= 11'd1024;
		end else if (cfg_we) begin
			unique case (lbc_pkg::reg_idx_t'(cfg_idx))
				lbc_pkg::REG_K0:     k0_q  <= cfg_data;
				lbc_pkg::REG_K1:     k1_q  <= cfg_data;
				lbc_pkg::REG_K2:     k2_q  <= cfg_data;
				lbc_pkg::REG_DIV:    div_q <= cfg_data[7:0];
				lbc_pkg::REG_OFFSET: off_q <= cfg_data[7:0];
				lbc_pkg::REG_WIDTH:  wid_q <= cfg_data[10:0];
				lbc_pkg::REG_HEIGHT: hgt_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	lbc_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.pixel_in(pixel_in), .k0(k0_q), .k1(k1_q), .k2(k2_q),
		.width_cfg(wid_q), .height_cfg(hgt_q),
		.item_valid(push), .item(fitem), .q_full(full)
	);

	lbc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(fitem), .full(full),
		.pop(pop), .not_empty(nempty), .dout(qitem)
	);

	lbc_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(nempty), .q_item(qitem), .q_pop(pop),
		.divisor_cfg(div_q), .offset_cfg(off_q),
		.valid(out_valid), .ready(out_ready), .out_value(out_value),
		.out_row(out_row), .out_col(out_col), .frame_last(frame_last)
	);
endmodule
`default_nettype wire

@@ hw/rtl/lbc_ram.sv @@
// Generic single-port-write, registered-read RAM
`default_nettype none
module lbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/lbc_front.sv @@
// Front end: pixel counters, line stores, window and weighted sum
`default_nettype none
module lbc_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        valid,
	output logic                       ready,
	input  wire  [lbc_pkg::PIX_W-1:0]  pixel_in,
	input  wire  [23:0]                k0,
	input  wire  [23:0]                k1,
	input  wire  [23:0]                k2,
	input  wire  [10:0]                width_cfg,
	input  wire  [10:0]                height_cfg,
	output logic                       item_valid,
	output lbc_pkg::win_item_t         item,
	input  wire                        q_full
);
	localparam int CW = lbc_pkg::COL_W;
	localparam int PW = lbc_pkg::PIX_W;

	lbc_pkg::fstate_t state_q, state_d;
	logic [9:0]  row_q;
	logic [9:0]  col_q;
	logic [PW-1:0] px_q;
	logic [PW-1:0] win_q [3][3];
	logic [PW-1:0] l0_rd, l1_rd;
	logic [10:0] w_eff, h_eff;
	logic        last_col, last_row, emit;
	logic [CW-1:0] addr;
	logic        wr_en;
	logic        emit_q, last_q;
	logic [9:0]  orow_q, ocol_q;
	logic [lbc_pkg::SUM_W-1:0] sum_c;
	logic [7:0]  kc [3][3];

	assign w_eff = (width_cfg < 11'd3) ? 11'd3 :
		(width_cfg > 11'(lbc_pkg::MAX_WIDTH) ? 11'(lbc_pkg::MAX_WIDTH) : width_cfg);
	assign h_eff = (height_cfg < 11'd3) ? 11'd3 :
		(height_cfg > 11'd1024 ? 11'd1024 : height_cfg);
	assign addr     = col_q[CW-1:0];
	assign last_col = ({1'b0, col_q} + 11'd1 >= w_eff);
	assign last_row = ({1'b0, row_q} + 11'd1 >= h_eff);
	assign emit     = (row_q >= 10'd2) && (col_q >= 10'd2);
	assign wr_en    = (state_q == lbc_pkg::FS_READ);

	lbc_ram #(.WIDTH(PW), .DEPTH(lbc_pkg::MAX_WIDTH)) u_line0 (
		.clk(clk), .we(wr_en), .waddr(addr), .wdata(l1_rd), .raddr(addr), .rdata(l0_rd)
	);
	lbc_ram #(.WIDTH(PW), .DEPTH(lbc_pkg::MAX_WIDTH)) u_line1 (
		.clk(clk), .we(wr_en), .waddr(addr), .wdata(px_q), .raddr(addr), .rdata(l1_rd)
	);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			kc[0][j] = k0[8*j +: 8];
			kc[1][j] = k1[8*j +: 8];
			kc[2][j] = k2[8*j +: 8];
		end
		sum_c = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				sum_c = sum_c + lbc_pkg::SUM_W'({8'd0, win_q[i][j]} * {8'd0, kc[i][j]});
	end

	always_comb begin
		state_d    = state_q;
		ready      = 1'b0;
		item_valid = 1'b0;
		unique case (state_q)
			lbc_pkg::FS_IDLE: begin
				ready = 1'b1;
				if (valid)
					state_d = lbc_pkg::FS_READ;
			end
			lbc_pkg::FS_READ: state_d = lbc_pkg::FS_SUM;
			lbc_pkg::FS_SUM: begin
				if (!emit_q) begin
					state_d = lbc_pkg::FS_IDLE;
				end else if (!q_full) begin
					item_valid = 1'b1;
					state_d    = lbc_pkg::FS_IDLE;
				end
			end
			default: state_d = lbc_pkg::FS_IDLE;
		endcase
	end

	assign item.sum  = sum_c;
	assign item.row  = orow_q;
	assign item.col  = ocol_q;
	assign item.last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbc_pkg::FS_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			emit_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lbc_pkg::FS_READ) begin
				emit_q <= emit;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? 10'd0 : row_q + 10'd1;
				end else begin
					col_q <= col_q + 10'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lbc_pkg::FS_IDLE && valid)
			px_q <= pixel_in;
		if (state_q == lbc_pkg::FS_READ) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= l0_rd;
			win_q[1][2] <= l1_rd;
			win_q[2][2] <= px_q;
			orow_q <= row_q - 10'd2;
			ocol_q <= col_q - 10'd2;
			last_q <= last_col && last_row;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/lbc_queue.sv @@
// Short FIFO between front and back ends
`default_nettype none
module lbc_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  lbc_pkg::win_item_t din,
	output logic               full,
	input  wire                pop,
	output logic               not_empty,
	output lbc_pkg::win_item_t dout
);
	lbc_pkg::win_item_t mem_q [lbc_pkg::QDEPTH];
	logic [lbc_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [lbc_pkg::QPTR_W:0]   cnt_q;

	assign full      = (cnt_q == (lbc_pkg::QPTR_W+1)'(lbc_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk)
		if (push)
			mem_q[wp_q] <= din;
endmodule
`default_nettype wire

@@ hw/rtl/lbc_back.sv @@
// Back end: restoring divider, offset add and output register
`default_nettype none
module lbc_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                q_valid,
	input  lbc_pkg::win_item_t q_item,
	output logic               q_pop,
	input  wire  [7:0]         divisor_cfg,
	input  wire  [7:0]         offset_cfg,
	output logic               valid,
	input  wire                ready,
	output logic [7:0]         out_value,
	output logic [9:0]         out_row,
	output logic [9:0]         out_col,
	output logic               frame_last
);
	localparam int SW = lbc_pkg::SUM_W;

	logic          busy_q;
	logic [4:0]    step_q;
	logic [SW-1:0] quo_q;
	logic [8:0]    rem_q;
	logic [7:0]    den;
	logic [9:0]    row_q, col_q;
	logic          last_q;
	logic [8:0]    trial;
	logic [9:0]    rsh;
	logic          done;

	assign den   = (divisor_cfg == 8'd0) ? 8'd1 : divisor_cfg;
	assign q_pop = q_valid && !busy_q && !valid;
	assign rsh   = {rem_q, quo_q[SW-1]};
	assign trial = rsh[8:0] - {1'b0, den};
	assign done  = busy_q && (step_q == 5'(SW-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			valid  <= 1'b0;
			step_q <= '0;
		end else begin
			if (valid && ready)
				valid <= 1'b0;
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (done) begin
					busy_q <= 1'b0;
					valid  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			quo_q  <= q_item.sum;
			rem_q  <= '0;
			row_q  <= q_item.row;
			col_q  <= q_item.col;
			last_q <= q_item.last;
		end else if (busy_q) begin
			if (rsh >= {2'b0, den}) begin
				rem_q <= trial;
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rsh[8:0];
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
			if (done) begin
				out_value  <= (rsh >= {2'b0, den} ? {quo_q[6:0], 1'b1}
					: {quo_q[6:0], 1'b0}) + offset_cfg;
				out_row    <= row_q;
				out_col    <= col_q;
				frame_last <= last_q;
			end
		end
	end
endmodule
`default_nettype wire
